[rtl/rgb_to_hsv_pixel_macros.svh]
// ----------------------------------------------------------------------------
// rgb_to_hsv_pixel_macros
// assertion macros shared by the rgb to hsv checker
// ----------------------------------------------------------------------------
`ifndef RGB_TO_HSV_PIXEL_MACROS_SVH
`define RGB_TO_HSV_PIXEL_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define RTHP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define RTHP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/rthp_pkg.sv]
// ----------------------------------------------------------------------------
// rthp_pkg
// shared widths, defaults, sector codes and sideband type of the rgb to hsv
// pipeline
// ----------------------------------------------------------------------------
package rthp_pkg;

  localparam int CH_W              = 8;
  localparam int HUE_W             = 15;
  localparam int SAT_W             = 13;
  localparam int IN_DATA_W         = 24;
  localparam int OUT_DATA_W        = 40;
  localparam int HUE_FRAC_BITS_DEF = 6;
  localparam int SAT_FRAC_BITS_DEF = 12;

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_t;

  typedef struct packed {
    logic [CH_W-1:0] brightness;
    sector_t         sector;
    logic            neg;
    logic            gray;
    logic            black;
  } side_t;

  // quotient bits needed by both dividers
  function automatic int quo_bits(input int hue_frac, input int sat_frac);
    int sat_q;
    int hue_q;
    sat_q = sat_frac + 1;
    hue_q = hue_frac + 6;
    return (sat_q > hue_q) ? sat_q : hue_q;
  endfunction

endpackage

[rtl/rthp_prep.sv]
// ----------------------------------------------------------------------------
// rthp_prep
// two front stages: max, min and sector pick, then delta, hue difference
// magnitude and the two dividends
// ----------------------------------------------------------------------------
module rthp_prep #(
  parameter int HUE_FRAC_BITS = rthp_pkg::HUE_FRAC_BITS_DEF,
  parameter int SAT_FRAC_BITS = rthp_pkg::SAT_FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 en,
  input  logic                                 in_valid,
  input  logic [rthp_pkg::CH_W-1:0]            blue,
  input  logic [rthp_pkg::CH_W-1:0]            green,
  input  logic [rthp_pkg::CH_W-1:0]            red,
  output logic                                 out_valid,
  output rthp_pkg::side_t                      out_side,
  output logic [rthp_pkg::quo_bits(HUE_FRAC_BITS, SAT_FRAC_BITS)+rthp_pkg::CH_W-1:0] num_s,
  output logic [rthp_pkg::quo_bits(HUE_FRAC_BITS, SAT_FRAC_BITS)+rthp_pkg::CH_W-1:0] num_h,
  output logic [rthp_pkg::CH_W-1:0]            den_h
);

  localparam int CH_W  = rthp_pkg::CH_W;
  localparam int DIV_Q = rthp_pkg::quo_bits(HUE_FRAC_BITS, SAT_FRAC_BITS);
  localparam int NUM_W = DIV_Q + CH_W;
  localparam logic [NUM_W-1:0] SIXTY = NUM_W'(60) << HUE_FRAC_BITS;

  logic                   s1_vld_r;
  logic [CH_W-1:0]        s1_hi_r, s1_hi_nxt;
  logic [CH_W-1:0]        s1_lo_r, s1_lo_nxt;
  rthp_pkg::sector_t      s1_sec_r, s1_sec_nxt;
  logic signed [CH_W:0]   s1_diff_r, s1_diff_nxt;

  logic                   s2_vld_r;
  rthp_pkg::side_t        s2_side_r, s2_side_nxt;
  logic [NUM_W-1:0]       s2_num_s_r, s2_num_s_nxt;
  logic [NUM_W-1:0]       s2_num_h_r, s2_num_h_nxt;
  logic [CH_W-1:0]        s2_den_r, s2_den_nxt;

  logic [CH_W-1:0]        delta;
  logic [CH_W:0]          abs_diff;

  // max, min and sector, red first on ties
  always_comb begin
    s1_hi_nxt = red;
    if (green > s1_hi_nxt) s1_hi_nxt = green;
    if (blue > s1_hi_nxt)  s1_hi_nxt = blue;
    s1_lo_nxt = red;
    if (green < s1_lo_nxt) s1_lo_nxt = green;
    if (blue < s1_lo_nxt)  s1_lo_nxt = blue;
    if (red == s1_hi_nxt) begin
      s1_sec_nxt  = rthp_pkg::SEC_RED;
      s1_diff_nxt = $signed({1'b0, green}) - $signed({1'b0, blue});
    end else if (green == s1_hi_nxt) begin
      s1_sec_nxt  = rthp_pkg::SEC_GREEN;
      s1_diff_nxt = $signed({1'b0, blue}) - $signed({1'b0, red});
    end else begin
      s1_sec_nxt  = rthp_pkg::SEC_BLUE;
      s1_diff_nxt = $signed({1'b0, red}) - $signed({1'b0, green});
    end
  end

  // dividends and sideband
  always_comb begin
    delta    = s1_hi_r - s1_lo_r;
    abs_diff = s1_diff_r[CH_W] ? ((CH_W+1)'(0) - s1_diff_r) : s1_diff_r;
    s2_num_s_nxt = NUM_W'(delta) << SAT_FRAC_BITS;
    s2_num_h_nxt = NUM_W'(abs_diff[CH_W-1:0]) * SIXTY;
    s2_den_nxt   = delta;
    s2_side_nxt.brightness = s1_hi_r;
    s2_side_nxt.sector     = s1_sec_r;
    s2_side_nxt.neg        = s1_diff_r[CH_W];
    s2_side_nxt.gray       = (delta == '0);
    s2_side_nxt.black      = (s1_hi_r == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_valid;
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_hi_r    <= s1_hi_nxt;
      s1_lo_r    <= s1_lo_nxt;
      s1_sec_r   <= s1_sec_nxt;
      s1_diff_r  <= s1_diff_nxt;
      s2_side_r  <= s2_side_nxt;
      s2_num_s_r <= s2_num_s_nxt;
      s2_num_h_r <= s2_num_h_nxt;
      s2_den_r   <= s2_den_nxt;
    end
  end

  assign out_valid = s2_vld_r;
  assign out_side  = s2_side_r;
  assign num_s     = s2_num_s_r;
  assign num_h     = s2_num_h_r;
  assign den_h     = s2_den_r;

endmodule

[rtl/rthp_div.sv]
// ----------------------------------------------------------------------------
// rthp_div
// dual-lane pipelined restoring divider, one quotient bit per stage, for
// saturation and hue magnitude side by side
// ----------------------------------------------------------------------------
module rthp_div #(
  parameter int HUE_FRAC_BITS = rthp_pkg::HUE_FRAC_BITS_DEF,
  parameter int SAT_FRAC_BITS = rthp_pkg::SAT_FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 en,
  input  logic                                 in_valid,
  input  rthp_pkg::side_t                      in_side,
  input  logic [rthp_pkg::quo_bits(HUE_FRAC_BITS, SAT_FRAC_BITS)+rthp_pkg::CH_W-1:0] num_s,
  input  logic [rthp_pkg::quo_bits(HUE_FRAC_BITS, SAT_FRAC_BITS)+rthp_pkg::CH_W-1:0] num_h,
  input  logic [rthp_pkg::CH_W-1:0]            den_h,
  output logic                                 out_valid,
  output rthp_pkg::side_t                      out_side,
  output logic [rthp_pkg::quo_bits(HUE_FRAC_BITS, SAT_FRAC_BITS)-1:0] quo_s,
  output logic [rthp_pkg::quo_bits(HUE_FRAC_BITS, SAT_FRAC_BITS)-1:0] quo_h
);

  localparam int CH_W  = rthp_pkg::CH_W;
  localparam int DIV_Q = rthp_pkg::quo_bits(HUE_FRAC_BITS, SAT_FRAC_BITS);
  localparam int NUM_W = DIV_Q + CH_W;

  typedef struct packed {
    logic [CH_W-1:0]  den;
    logic [CH_W-1:0]  rem;
    logic [DIV_Q-1:0] nq;
  } lane_t;

  // one restoring step: numerator bits shift out, quotient bits shift in
  function automatic lane_t div_step(input lane_t cur);
    logic [CH_W:0] trial;
    logic          qbit;
    lane_t         nxt;
    trial = {cur.rem, cur.nq[DIV_Q-1]};
    nxt   = cur;
    qbit  = (trial >= {1'b0, cur.den});
    if (qbit) begin
      nxt.rem = CH_W'(trial - {1'b0, cur.den});
    end else begin
      nxt.rem = trial[CH_W-1:0];
    end
    nxt.nq = {cur.nq[DIV_Q-2:0], qbit};
    return nxt;
  endfunction

  lane_t            s_in;
  lane_t            h_in;
  logic [DIV_Q-1:0] vld_r;
  lane_t            sat_r  [DIV_Q];
  lane_t            hue_r  [DIV_Q];
  rthp_pkg::side_t  side_r [DIV_Q];

  always_comb begin
    s_in.den = in_side.brightness;
    s_in.rem = num_s[NUM_W-1:DIV_Q];
    s_in.nq  = num_s[DIV_Q-1:0];
    h_in.den = den_h;
    h_in.rem = num_h[NUM_W-1:DIV_Q];
    h_in.nq  = num_h[DIV_Q-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[DIV_Q-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sat_r[0]  <= div_step(s_in);
      hue_r[0]  <= div_step(h_in);
      side_r[0] <= in_side;
      for (int k = 1; k < DIV_Q; k++) begin
        sat_r[k]  <= div_step(sat_r[k-1]);
        hue_r[k]  <= div_step(hue_r[k-1]);
        side_r[k] <= side_r[k-1];
      end
    end
  end

  assign out_valid = vld_r[DIV_Q-1];
  assign out_side  = side_r[DIV_Q-1];
  assign quo_s     = sat_r[DIV_Q-1].nq;
  assign quo_h     = hue_r[DIV_Q-1].nq;

endmodule

[rtl/rthp_post.sv]
// ----------------------------------------------------------------------------
// rthp_post
// final stage: hue sign, sector offset and wrap, gray and black overrides,
// output register
// ----------------------------------------------------------------------------
module rthp_post #(
  parameter int HUE_FRAC_BITS = rthp_pkg::HUE_FRAC_BITS_DEF,
  parameter int SAT_FRAC_BITS = rthp_pkg::SAT_FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 en,
  input  logic                                 in_valid,
  input  rthp_pkg::side_t                      in_side,
  input  logic [rthp_pkg::quo_bits(HUE_FRAC_BITS, SAT_FRAC_BITS)-1:0] quo_s,
  input  logic [rthp_pkg::quo_bits(HUE_FRAC_BITS, SAT_FRAC_BITS)-1:0] quo_h,
  output logic                                 out_valid,
  output logic [rthp_pkg::HUE_W-1:0]           hue,
  output logic [rthp_pkg::SAT_W-1:0]           saturation,
  output logic [rthp_pkg::CH_W-1:0]            brightness
);

  localparam int HUE_W = rthp_pkg::HUE_W;
  localparam int SAT_W = rthp_pkg::SAT_W;
  localparam int CH_W  = rthp_pkg::CH_W;
  localparam int DIV_Q = rthp_pkg::quo_bits(HUE_FRAC_BITS, SAT_FRAC_BITS);
  localparam int HW    = HUE_FRAC_BITS + 11;
  localparam logic signed [HW-1:0] SIXTY = HW'(60) << HUE_FRAC_BITS;
  localparam logic signed [HW-1:0] FULL  = HW'(360) << HUE_FRAC_BITS;

  logic signed [HW-1:0]      base;
  logic signed [HW-1:0]      mag;
  logic signed [HW-1:0]      hue_raw;
  logic [HW+HUE_W-1:0]       hue_ext;
  logic [DIV_Q+SAT_W-1:0]    sat_ext;

  logic                      out_valid_r;
  logic [HUE_W-1:0]          hue_r, hue_nxt;
  logic [SAT_W-1:0]          sat_r, sat_nxt;
  logic [CH_W-1:0]           bri_r;

  always_comb begin
    case (in_side.sector)
      rthp_pkg::SEC_RED:   base = '0;
      rthp_pkg::SEC_GREEN: base = SIXTY <<< 1;
      rthp_pkg::SEC_BLUE:  base = SIXTY <<< 2;
      default:             base = '0;
    endcase
    mag     = HW'(quo_h);
    hue_raw = in_side.neg ? (base - mag) : (base + mag);
    if (hue_raw < 0) hue_raw = hue_raw + FULL;
    if (in_side.gray) hue_raw = '0;
    hue_ext = {{HUE_W{1'b0}}, hue_raw};
    hue_nxt = hue_ext[HUE_W-1:0];
    sat_ext = {{SAT_W{1'b0}}, quo_s};
    sat_nxt = in_side.black ? '0 : sat_ext[SAT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hue_r <= hue_nxt;
      sat_r <= sat_nxt;
      bri_r <= in_side.brightness;
    end
  end

  assign out_valid  = out_valid_r;
  assign hue        = hue_r;
  assign saturation = sat_r;
  assign brightness = bri_r;

endmodule

[rtl/rgb_to_hsv_pixel.sv]
// ----------------------------------------------------------------------------
// rgb_to_hsv_pixel
// rgb to hsv pixel converter, streaming in and out
// ----------------------------------------------------------------------------
// takes one 8-bit rgb pixel per clock and returns brightness (largest
// channel), saturation in 1/2^SAT_FRAC_BITS and hue in 1/2^HUE_FRAC_BITS
// degree; gray pixels give hue 0, black gives saturation 0. with
// Q = max(SAT_FRAC_BITS + 1, HUE_FRAC_BITS + 6), the pipeline holds
// two front stages, Q divider stages that each resolve one
// quotient bit of both divisions, and the output register. the whole
// pipeline advances when the output register is empty or taken, so a
// stalled output holds every stage and in_tready drops with it.
// ----------------------------------------------------------------------------
module rgb_to_hsv_pixel #(
  parameter int HUE_FRAC_BITS = rthp_pkg::HUE_FRAC_BITS_DEF,
  parameter int SAT_FRAC_BITS = rthp_pkg::SAT_FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [rthp_pkg::IN_DATA_W-1:0]        in_tdata,   // blue, green, red
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [rthp_pkg::OUT_DATA_W-1:0]       out_tdata   // hue, saturation, brightness, zero pad
);

  localparam int CH_W  = rthp_pkg::CH_W;
  localparam int DIV_Q = rthp_pkg::quo_bits(HUE_FRAC_BITS, SAT_FRAC_BITS);
  localparam int NUM_W = DIV_Q + CH_W;
  localparam int PAD_W = rthp_pkg::OUT_DATA_W - rthp_pkg::HUE_W - rthp_pkg::SAT_W - CH_W;

  logic                        en;
  logic                        prep_vld;
  rthp_pkg::side_t             prep_side;
  logic [NUM_W-1:0]            prep_num_s;
  logic [NUM_W-1:0]            prep_num_h;
  logic [CH_W-1:0]             prep_den_h;
  logic                        div_vld;
  rthp_pkg::side_t             div_side;
  logic [DIV_Q-1:0]            div_quo_s;
  logic [DIV_Q-1:0]            div_quo_h;
  logic [rthp_pkg::HUE_W-1:0]  hue;
  logic [rthp_pkg::SAT_W-1:0]  saturation;
  logic [CH_W-1:0]             brightness;

  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  rthp_prep #(
    .HUE_FRAC_BITS (HUE_FRAC_BITS),
    .SAT_FRAC_BITS (SAT_FRAC_BITS)
  ) u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_tvalid),
    .blue      (in_tdata[CH_W-1:0]),
    .green     (in_tdata[2*CH_W-1:CH_W]),
    .red       (in_tdata[3*CH_W-1:2*CH_W]),
    .out_valid (prep_vld),
    .out_side  (prep_side),
    .num_s     (prep_num_s),
    .num_h     (prep_num_h),
    .den_h     (prep_den_h)
  );

  rthp_div #(
    .HUE_FRAC_BITS (HUE_FRAC_BITS),
    .SAT_FRAC_BITS (SAT_FRAC_BITS)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (prep_vld),
    .in_side   (prep_side),
    .num_s     (prep_num_s),
    .num_h     (prep_num_h),
    .den_h     (prep_den_h),
    .out_valid (div_vld),
    .out_side  (div_side),
    .quo_s     (div_quo_s),
    .quo_h     (div_quo_h)
  );

  rthp_post #(
    .HUE_FRAC_BITS (HUE_FRAC_BITS),
    .SAT_FRAC_BITS (SAT_FRAC_BITS)
  ) u_post (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_valid   (div_vld),
    .in_side    (div_side),
    .quo_s      (div_quo_s),
    .quo_h      (div_quo_h),
    .out_valid  (out_tvalid),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness)
  );

  assign out_tdata = {{PAD_W{1'b0}}, brightness, saturation, hue};

endmodule

[rtl/rthp_checker.sv]
// ----------------------------------------------------------------------------
// rthp_checker
// port-level checks of the rgb to hsv converter, bound to the top level
// ----------------------------------------------------------------------------
`include "rgb_to_hsv_pixel_macros.svh"

module rthp_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [rthp_pkg::IN_DATA_W-1:0]  in_tdata,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [rthp_pkg::OUT_DATA_W-1:0] out_tdata
);

  localparam int HS_W  = rthp_pkg::HUE_W + rthp_pkg::SAT_W;
  localparam int VAL_W = HS_W + rthp_pkg::CH_W;

  logic [rthp_pkg::CH_W-1:0] bri;
  logic                      in_idle;

  assign bri     = out_tdata[VAL_W-1:HS_W];
  assign in_idle = !in_tvalid && (in_tdata == in_tdata);

  // a waiting result stays put
  `RTHP_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result changed")

  // a full output stage holds the whole pipeline
  `RTHP_ASSERT_IMP(a_stall_blocks_in, out_tvalid && !out_tready, !in_tready, "input taken during output stall")

  // black pixel gives zero hue and saturation
  `RTHP_ASSERT_IMP(a_black_zero, out_tvalid && (bri == '0), out_tdata[HS_W-1:0] == '0, "black pixel with nonzero hue or saturation")

  // padding above brightness stays zero
  `RTHP_ASSERT_IMP(a_pad_zero, out_tvalid || in_idle, out_tdata[rthp_pkg::OUT_DATA_W-1:VAL_W] == '0, "nonzero padding")

endmodule

bind rgb_to_hsv_pixel rthp_checker u_rthp_checker (.*);

[tb/rgb_to_hsv_pixel_tb.sv]
// ----------------------------------------------------------------------------
// rgb_to_hsv_pixel_tb
// self-checking bench for the rgb to hsv pixel converter
// ----------------------------------------------------------------------------
// drives pixels on the input stream and checks every output transaction
// against a table result or an in-bench hsv calculation, field by field,
// in order. a short table of hand-picked pixels runs first, then random
// pixels in three phases, two throttling sender and receiver, with one
// long output stall that backs up the pipeline and a full drain between phases.
// ----------------------------------------------------------------------------
module rgb_to_hsv_pixel_tb;

  localparam int HUE_FRAC   = rthp_pkg::HUE_FRAC_BITS_DEF;
  localparam int SAT_FRAC   = rthp_pkg::SAT_FRAC_BITS_DEF;
  localparam int DEG60      = 60 << HUE_FRAC;
  localparam int DEG360     = 360 << HUE_FRAC;
  localparam int CYCLE_CAP  = 200000;
  localparam int SETTLE     = 40;
  localparam int PHASE_LEN  = 450;
  localparam int NUM_ROWS   = 22;

  typedef struct packed {
    logic [rthp_pkg::HUE_W-1:0] hue;
    logic [rthp_pkg::SAT_W-1:0] sat;
    logic [rthp_pkg::CH_W-1:0]  val;
  } hsv_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic       known;
    hsv_t       res;
  } pixel_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [rthp_pkg::IN_DATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [rthp_pkg::OUT_DATA_W-1:0] out_tdata;

  // typed result riding along with a table pixel
  logic row_known = 1'b0;
  hsv_t row_hsv = '0;

  hsv_t hsv_pending[$];
  int mismatch_count = 0;
  int results_seen = 0;
  int unsigned cycle_count = 0;
  int send_idle_pct = 21;
  int recv_idle_pct = 54;
  int hold_left = 0;
  bit held_once = 1'b0;

  pixel_row_t pixel_rows [0:NUM_ROWS-1] = '{
    '{8'd0,   8'd0,   8'd0,   1'b1, '{15'd0,     13'd0,    8'd0}},
    '{8'd255, 8'd255, 8'd255, 1'b1, '{15'd0,     13'd0,    8'd255}},
    '{8'd128, 8'd128, 8'd128, 1'b1, '{15'd0,     13'd0,    8'd128}},
    '{8'd1,   8'd1,   8'd1,   1'b1, '{15'd0,     13'd0,    8'd1}},
    '{8'd255, 8'd0,   8'd0,   1'b1, '{15'd0,     13'd4096, 8'd255}},
    '{8'd0,   8'd255, 8'd0,   1'b1, '{15'd7680,  13'd4096, 8'd255}},
    '{8'd0,   8'd0,   8'd255, 1'b1, '{15'd15360, 13'd4096, 8'd255}},
    '{8'd255, 8'd255, 8'd0,   1'b1, '{15'd3840,  13'd4096, 8'd255}},
    '{8'd0,   8'd255, 8'd255, 1'b1, '{15'd11520, 13'd4096, 8'd255}},
    '{8'd255, 8'd0,   8'd255, 1'b1, '{15'd19200, 13'd4096, 8'd255}},
    '{8'd1,   8'd0,   8'd0,   1'b1, '{15'd0,     13'd4096, 8'd1}},
    '{8'd255, 8'd0,   8'd1,   1'b0, '0},
    '{8'd254, 8'd255, 8'd0,   1'b0, '0},
    '{8'd0,   8'd1,   8'd255, 1'b0, '0},
    '{8'd128, 8'd128, 8'd127, 1'b0, '0},
    '{8'd127, 8'd128, 8'd128, 1'b0, '0},
    '{8'd254, 8'd254, 8'd255, 1'b0, '0},
    '{8'd255, 8'd254, 8'd253, 1'b0, '0},
    '{8'd1,   8'd2,   8'd3,   1'b0, '0},
    '{8'd200, 8'd100, 8'd150, 1'b0, '0},
    '{8'd170, 8'd85,  8'd0,   1'b0, '0},
    '{8'd100, 8'd200, 8'd250, 1'b0, '0}
  };

  rgb_to_hsv_pixel dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic hsv_t hsv_of_pixel(input logic [7:0] r, input logic [7:0] g,
                                        input logic [7:0] b);
    int hi;
    int lo;
    int dlt;
    int diff;
    int base;
    int mag;
    int h;
    hsv_t res;
    hi = (r > g) ? int'(r) : int'(g);
    hi = (hi > int'(b)) ? hi : int'(b);
    lo = (r < g) ? int'(r) : int'(g);
    lo = (lo < int'(b)) ? lo : int'(b);
    dlt = hi - lo;
    h = 0;
    res.val = hi[7:0];
    res.sat = (hi == 0) ? '0 : 13'((dlt << SAT_FRAC) / hi);
    if (dlt != 0) begin
      if (int'(r) == hi) begin
        diff = int'(g) - int'(b);
        base = 0;
      end else if (int'(g) == hi) begin
        diff = int'(b) - int'(r);
        base = 2 * DEG60;
      end else begin
        diff = int'(r) - int'(g);
        base = 4 * DEG60;
      end
      mag = (DEG60 * ((diff < 0) ? -diff : diff)) / dlt;
      h = base + ((diff < 0) ? -mag : mag);
      if (h < 0) h += DEG360;
    end
    res.hue = 15'(h);
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got_v, input int want_v);
    mismatch_count++;
    if (mismatch_count <= 40)
      $display("cycle %0d: %s got %0d expected %0d", cycle_count, what, got_v, want_v);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_CAP) begin
      $display("rgb_to_hsv_pixel: mismatch");
      $finish;
    end
  end

  // receiver, with one long hold-off once results are flowing
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (!held_once && results_seen >= 150) begin
        hold_left = 300;
        held_once = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // transaction monitor on both sides
  always @(posedge clk) begin : monitor
    hsv_t got;
    hsv_t want;
    hsv_t exp_hsv;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        exp_hsv = row_known ? row_hsv
                  : hsv_of_pixel(in_tdata[23:16], in_tdata[15:8], in_tdata[7:0]);
        hsv_pending = {hsv_pending, exp_hsv};
      end
      if (out_tvalid && out_tready) begin
        got.hue = out_tdata[14:0];
        got.sat = out_tdata[27:15];
        got.val = out_tdata[35:28];
        results_seen++;
        if (hsv_pending.size() == 0) begin
          report_mismatch("unexpected result, hue", int'(got.hue), -1);
        end else begin
          want = hsv_pending.pop_front();
          if (got.hue != want.hue)
            report_mismatch("hue", int'(got.hue), int'(want.hue));
          if (got.sat != want.sat)
            report_mismatch("saturation", int'(got.sat), int'(want.sat));
          if (got.val != want.val)
            report_mismatch("brightness", int'(got.val), int'(want.val));
        end
      end
    end
  end

  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                            input logic known, input hsv_t res);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {r, g, b};
    row_known <= known;
    row_hsv   <= res;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic pick_pixel(output logic [7:0] r, output logic [7:0] g, output logic [7:0] b);
    logic [7:0] c;
    int kind;
    kind = $urandom_range(9);
    r = 8'($urandom_range(255));
    g = 8'($urandom_range(255));
    b = 8'($urandom_range(255));
    c = 8'($urandom_range(255));
    case (kind)
      5: begin
        g = r;
        b = r;
      end
      6: begin
        case ($urandom_range(2))
          0: g = r;
          1: b = g;
          default: r = b;
        endcase
      end
      7: begin
        r = 8'($urandom_range(3));
        g = 8'($urandom_range(3));
        b = 8'($urandom_range(3));
      end
      8: begin
        case ($urandom_range(2))
          0: r = 8'd255;
          1: g = 8'd255;
          default: b = 8'd255;
        endcase
      end
      9: begin
        c = 8'($urandom_range(250, 3));
        r = c + 8'($urandom_range(4)) - 8'd2;
        g = c + 8'($urandom_range(4)) - 8'd2;
        b = c + 8'($urandom_range(4)) - 8'd2;
      end
      default: ;
    endcase
  endtask

  task automatic send_random(input int count);
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    repeat (count) begin
      pick_pixel(r, g, b);
      send_pixel(r, g, b, 1'b0, '0);
    end
  endtask

  task automatic drain_pending();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (hsv_pending.size() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (pixel_rows[i])
      send_pixel(pixel_rows[i].r, pixel_rows[i].g, pixel_rows[i].b,
                 pixel_rows[i].known, pixel_rows[i].res);
    send_random(PHASE_LEN);
    drain_pending();

    send_idle_pct = 54;
    recv_idle_pct = 21;
    send_random(PHASE_LEN);
    drain_pending();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random(PHASE_LEN);
    drain_pending();

    repeat (SETTLE) @(posedge clk);
    if (mismatch_count == 0)
      $display("rgb_to_hsv_pixel: match");
    else
      $display("rgb_to_hsv_pixel: mismatch");
    $finish;
  end

endmodule
